// ===== rtl/core/dsf_pkg.sv =====
package dsf_pkg;

  // field and register widths
  localparam int unsigned SPLIT_W    = 16;
  localparam int unsigned MAGIC_W    = 32;
  localparam int unsigned LEN_W      = 24;
  localparam int unsigned SEQ_W      = 32;
  localparam int unsigned TOTAL_W    = 8;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 32;

  // fragment header layout
  localparam int unsigned HEADER_BYTES = 10;
  localparam int unsigned HDR_CNT_W    = $clog2(HEADER_BYTES);

  // default depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  // register reset values
  localparam logic [SPLIT_W-1:0] SPLIT_SIZE_RST = 16'd1400;
  localparam logic [MAGIC_W-1:0] MAGIC_WORD_RST = 32'hFFFF_FFFE;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SPLIT_SIZE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAGIC_WORD = 1'd1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_SMALL    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_TOO_MANY = 2'd2;

  // classified byte handed from front to back
  typedef struct packed {
    logic [7:0]          data;
    logic                first;
    logic [LEN_W-1:0]    len;
    logic [SEQ_W-1:0]    seq;
    logic [TOTAL_W-1:0]  total;
    logic [STATUS_W-1:0] status;
  } dsf_entry_t;

endpackage

// ===== rtl/core/dsf_front.sv =====
module dsf_front
  import dsf_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [SPLIT_W-1:0]         split_size_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [7:0]                 data_byte_i,
  input  logic                       first_byte_i,
  input  logic [LEN_W-1:0]           payload_length_i,
  input  logic signed [SEQ_W-1:0]    payload_seq_i,
  input  logic                       full_i,
  output logic                       push_o,
  output dsf_entry_t                 push_data_o
);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_CHK  = 2'd1;
  localparam logic [1:0] F_DIV  = 2'd2;
  localparam logic [1:0] F_PUSH = 2'd3;

  localparam int unsigned STEP_W = $clog2(TOTAL_W);

  logic [1:0]         state_q, state_d;
  logic [STEP_W-1:0]  step_q, step_d;
  dsf_entry_t         ent_q, ent_d;
  logic [SPLIT_W-1:0] body_q, body_d;
  logic               small_q, small_d;
  logic [LEN_W-1:0]   rem_q, rem_d;
  logic [LEN_W-1:0]   dv_q, dv_d;
  logic [TOTAL_W-1:0] quo_q, quo_d;

  logic               accept;
  logic [LEN_W-1:0]   len_eff;
  logic [LEN_W-1:0]   max_len;
  logic               ge;
  logic [TOTAL_W-1:0] quo_next;

  assign in_ready_o = (state_q == F_IDLE) && !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign len_eff    = (payload_length_i == '0) ? LEN_W'(1) : payload_length_i;

  // largest length that still fits in the fragment limit: 255 * body
  assign max_len  = (LEN_W'(body_q) << TOTAL_W) - LEN_W'(body_q);
  assign ge       = rem_q >= dv_q;
  assign quo_next = {quo_q[TOTAL_W-2:0], ge};

  // non-first bytes go straight into the queue, first bytes are classified
  always_comb begin
    push_o      = 1'b0;
    push_data_o = ent_q;
    state_d     = state_q;
    step_d      = step_q;
    ent_d       = ent_q;
    body_d      = body_q;
    small_d     = small_q;
    rem_d       = rem_q;
    dv_d        = dv_q;
    quo_d       = quo_q;
    case (state_q)
      F_IDLE: begin
        push_data_o.data   = data_byte_i;
        push_data_o.first  = 1'b0;
        push_data_o.len    = len_eff;
        push_data_o.seq    = $unsigned(payload_seq_i);
        push_data_o.total  = '0;
        push_data_o.status = ST_OK;
        if (accept) begin
          if (first_byte_i) begin
            ent_d         = push_data_o;
            ent_d.first   = 1'b1;
            body_d        = split_size_i - SPLIT_W'(HEADER_BYTES);
            small_d       = split_size_i <= SPLIT_W'(HEADER_BYTES);
            state_d       = F_CHK;
          end else begin
            push_o = 1'b1;
          end
        end
      end
      F_CHK: begin
        if (small_q) begin
          ent_d.status = ST_SMALL;
          state_d      = F_PUSH;
        end else if (ent_q.len > max_len) begin
          ent_d.status = ST_TOO_MANY;
          state_d      = F_PUSH;
        end else begin
          // ceil(len / body) = (len - 1) / body + 1
          rem_d   = ent_q.len - LEN_W'(1);
          dv_d    = LEN_W'(body_q) << (TOTAL_W - 1);
          quo_d   = '0;
          step_d  = STEP_W'(TOTAL_W - 1);
          state_d = F_DIV;
        end
      end
      F_DIV: begin
        // one quotient bit per cycle, restoring
        if (ge) begin
          rem_d = rem_q - dv_q;
        end
        dv_d  = dv_q >> 1;
        quo_d = quo_next;
        if (step_q == '0) begin
          ent_d.total = quo_next + TOTAL_W'(1);
          state_d     = F_PUSH;
        end else begin
          step_d = step_q - STEP_W'(1);
        end
      end
      F_PUSH: begin
        if (!full_i) begin
          push_o  = 1'b1;
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    ent_q   <= ent_d;
    body_q  <= body_d;
    small_q <= small_d;
    rem_q   <= rem_d;
    dv_q    <= dv_d;
    quo_q   <= quo_d;
  end

  // checks
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> !full_i)
    else $error("front pushes into a full queue");

  a_div_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == F_DIV) |-> !small_q && (ent_q.len <= max_len))
    else $error("division started for an out of range payload");

  a_push_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == F_PUSH && ent_q.status == ST_OK) |-> (ent_q.total != '0))
    else $error("good first byte carries zero fragment count");

endmodule

// ===== rtl/core/dsf_queue.sv =====
module dsf_queue
  import dsf_pkg::*;
#(
  parameter int unsigned Depth = QUEUE_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  dsf_entry_t push_data_i,
  input  logic       pop_i,
  output dsf_entry_t head_o,
  output logic       full_o,
  output logic       empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  dsf_entry_t      mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = cnt_q == CntW'(Depth);
  assign empty_o = cnt_q == '0;
  assign head_o  = mem_q[rd_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  // checks
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("queue count out of range");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from empty queue");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |-> !full_o)
    else $error("push into full queue");

endmodule

// ===== rtl/core/dsf_back.sv =====
module dsf_back
  import dsf_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [SPLIT_W-1:0]  split_size_i,
  input  logic [MAGIC_W-1:0]  magic_word_i,
  input  dsf_entry_t          head_i,
  input  logic                empty_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [7:0]          out_byte_o,
  output logic                fragment_end_o,
  output logic                run_last_o,
  output logic [STATUS_W-1:0] status_o
);

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_ERR  = 2'd1;
  localparam logic [1:0] B_HDR  = 2'd2;
  localparam logic [1:0] B_BODY = 2'd3;

  // header byte positions
  localparam logic [HDR_CNT_W-1:0] HDR_MAGIC0 = 4'd0;
  localparam logic [HDR_CNT_W-1:0] HDR_MAGIC1 = 4'd1;
  localparam logic [HDR_CNT_W-1:0] HDR_MAGIC2 = 4'd2;
  localparam logic [HDR_CNT_W-1:0] HDR_MAGIC3 = 4'd3;
  localparam logic [HDR_CNT_W-1:0] HDR_SEQ0   = 4'd4;
  localparam logic [HDR_CNT_W-1:0] HDR_SEQ1   = 4'd5;
  localparam logic [HDR_CNT_W-1:0] HDR_SEQ2   = 4'd6;
  localparam logic [HDR_CNT_W-1:0] HDR_SEQ3   = 4'd7;
  localparam logic [HDR_CNT_W-1:0] HDR_TOTAL  = 4'd8;
  localparam logic [HDR_CNT_W-1:0] HDR_INDEX  = 4'd9;

  logic [1:0]           state_q, state_d;
  logic [HDR_CNT_W-1:0] hcnt_q, hcnt_d;
  logic [TOTAL_W-1:0]   idx_q, idx_d;
  logic [TOTAL_W-1:0]   total_q, total_d;
  logic [SPLIT_W-1:0]   done_q, done_d;
  logic [LEN_W-1:0]     rem_q, rem_d;
  logic [SEQ_W-1:0]     seq_q, seq_d;
  logic                 drop_q, drop_d;

  logic                 out_valid_q, out_valid_d;
  logic [7:0]           out_byte_q, out_byte_d;
  logic                 fend_q, fend_d;
  logic                 last_q, last_d;
  logic [STATUS_W-1:0]  status_q, status_d;

  logic                 slot_free;
  logic                 load;
  logic                 head_err;
  logic                 eff_drop;
  logic [LEN_W-1:0]     eff_rem;
  logic [SPLIT_W-1:0]   eff_done;
  logic [SPLIT_W-1:0]   body;
  logic [SPLIT_W-1:0]   done_inc;
  logic [LEN_W-1:0]     rem_dec;
  logic                 fend;
  logic [7:0]           hdr_byte;

  assign slot_free = !out_valid_q || out_ready_i;
  assign head_err  = head_i.first && (head_i.status != ST_OK);

  // state as seen after a possible payload start
  assign eff_drop = head_i.first ? head_err : drop_q;
  assign eff_rem  = head_i.first ? (head_err ? '0 : head_i.len) : rem_q;
  assign eff_done = head_i.first ? '0 : done_q;

  // body size follows the live split size
  assign body     = (split_size_i <= SPLIT_W'(HEADER_BYTES)) ? SPLIT_W'(1)
                  : split_size_i - SPLIT_W'(HEADER_BYTES);
  assign done_inc = done_q + SPLIT_W'(1);
  assign rem_dec  = rem_q - LEN_W'(1);
  assign fend     = (done_inc >= body) || (rem_dec == '0);

  // header byte mux, little endian
  always_comb begin
    case (hcnt_q)
      HDR_MAGIC0: hdr_byte = magic_word_i[7:0];
      HDR_MAGIC1: hdr_byte = magic_word_i[15:8];
      HDR_MAGIC2: hdr_byte = magic_word_i[23:16];
      HDR_MAGIC3: hdr_byte = magic_word_i[31:24];
      HDR_SEQ0:   hdr_byte = seq_q[7:0];
      HDR_SEQ1:   hdr_byte = seq_q[15:8];
      HDR_SEQ2:   hdr_byte = seq_q[23:16];
      HDR_SEQ3:   hdr_byte = seq_q[31:24];
      HDR_TOTAL:  hdr_byte = total_q;
      HDR_INDEX:  hdr_byte = idx_q;
      default:    hdr_byte = '0;
    endcase
  end

  // sequencer
  always_comb begin
    state_d    = state_q;
    hcnt_d     = hcnt_q;
    idx_d      = idx_q;
    total_d    = total_q;
    done_d     = done_q;
    rem_d      = rem_q;
    seq_d      = seq_q;
    drop_d     = drop_q;
    pop_o      = 1'b0;
    load       = 1'b0;
    out_byte_d = out_byte_q;
    fend_d     = fend_q;
    last_d     = last_q;
    status_d   = status_q;
    case (state_q)
      B_IDLE: begin
        if (!empty_i) begin
          if (head_i.first) begin
            seq_d   = head_i.seq;
            idx_d   = '0;
            done_d  = '0;
            total_d = head_err ? '0 : head_i.total;
            drop_d  = eff_drop;
            rem_d   = eff_rem;
          end
          if (head_err) begin
            state_d = B_ERR;
          end else if (eff_drop || eff_rem == '0) begin
            pop_o = 1'b1;
          end else if (eff_done == '0) begin
            hcnt_d  = '0;
            state_d = B_HDR;
          end else begin
            state_d = B_BODY;
          end
        end
      end
      B_ERR: begin
        if (slot_free) begin
          load       = 1'b1;
          out_byte_d = '0;
          fend_d     = 1'b0;
          last_d     = 1'b1;
          status_d   = head_i.status;
          pop_o      = 1'b1;
          state_d    = B_IDLE;
        end
      end
      B_HDR: begin
        if (slot_free) begin
          load       = 1'b1;
          out_byte_d = hdr_byte;
          fend_d     = 1'b0;
          last_d     = 1'b0;
          status_d   = ST_OK;
          if (hcnt_q == HDR_INDEX) begin
            state_d = B_BODY;
          end else begin
            hcnt_d = hcnt_q + HDR_CNT_W'(1);
          end
        end
      end
      B_BODY: begin
        if (slot_free) begin
          load       = 1'b1;
          out_byte_d = head_i.data;
          fend_d     = fend;
          last_d     = 1'b1;
          status_d   = ST_OK;
          rem_d      = rem_dec;
          if (fend) begin
            done_d = '0;
            idx_d  = idx_q + TOTAL_W'(1);
          end else begin
            done_d = done_inc;
          end
          pop_o   = 1'b1;
          state_d = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  // output register valid
  always_comb begin
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // control state and payload position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      hcnt_q      <= '0;
      idx_q       <= '0;
      total_q     <= '0;
      done_q      <= '0;
      rem_q       <= '0;
      seq_q       <= '0;
      drop_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      hcnt_q      <= hcnt_d;
      idx_q       <= idx_d;
      total_q     <= total_d;
      done_q      <= done_d;
      rem_q       <= rem_d;
      seq_q       <= seq_d;
      drop_q      <= drop_d;
      out_valid_q <= out_valid_d;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_byte_q <= out_byte_d;
      fend_q     <= fend_d;
      last_q     <= last_d;
      status_q   <= status_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_byte_o     = out_byte_q;
  assign fragment_end_o = fend_q;
  assign run_last_o     = last_q;
  assign status_o       = status_q;

  // checks
  a_err_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ST_OK) |-> run_last_o && !fragment_end_o
      && (out_byte_o == '0))
    else $error("error result malformed");

  a_fend_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && fragment_end_o) |-> run_last_o)
    else $error("fragment end on a header byte");

  a_hdr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_HDR) |-> (hcnt_q <= HDR_INDEX))
    else $error("header counter past last header byte");

endmodule

// ===== rtl/core/datagram_split_fragmenter_top.sv =====
// channel   direction  handshake                  payload
// input     in         in_valid_i / in_ready_o    data_byte, first_byte, payload_length,
//                                                 payload_seq
// output    out        out_valid_o / out_ready_i  out_byte, fragment_end, run_last, status
// config    in         cfg_we_i                   cfg_idx_i, cfg_wdata_i
//
// a payload byte inside a fragment passes the back sequencer's idle state and body state
// (idle finds it at the queue head, body loads the output register and pops it)
// a byte that opens a fragment first passes the header state for the header bytes
// a first byte also passes through the front's check and division states: a range check and a
// restoring division for the fragment count, one quotient bit a cycle
// reset is asynchronous, active low, and needs no clearing pass
// front and back stall on their own across the queue; output stalls back up
// through the output register, the queue and then in_ready_o
module datagram_split_fragmenter_top
  import dsf_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [7:0]              data_byte_i,
  input  logic                    first_byte_i,
  input  logic [LEN_W-1:0]        payload_length_i,
  input  logic signed [SEQ_W-1:0] payload_seq_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [7:0]              out_byte_o,
  output logic                    fragment_end_o,
  output logic                    run_last_o,
  output logic [STATUS_W-1:0]     status_o
);

  logic [SPLIT_W-1:0] split_size_q;
  logic [MAGIC_W-1:0] magic_word_q;

  logic       push;
  dsf_entry_t push_data;
  logic       pop;
  dsf_entry_t head;
  logic       full;
  logic       empty;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      split_size_q <= SPLIT_SIZE_RST;
      magic_word_q <= MAGIC_WORD_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SPLIT_SIZE: split_size_q <= cfg_wdata_i[SPLIT_W-1:0];
        REG_MAGIC_WORD: magic_word_q <= cfg_wdata_i[MAGIC_W-1:0];
        default: ;
      endcase
    end
  end

  // classify incoming bytes
  dsf_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .split_size_i      (split_size_q),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .data_byte_i       (data_byte_i),
    .first_byte_i      (first_byte_i),
    .payload_length_i  (payload_length_i),
    .payload_seq_i     (payload_seq_i),
    .full_i            (full),
    .push_o            (push),
    .push_data_o       (push_data)
  );

  // decoupling queue
  dsf_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .full_o      (full),
    .empty_o     (empty)
  );

  // emit headers, bodies and errors
  dsf_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .split_size_i   (split_size_q),
    .magic_word_i   (magic_word_q),
    .head_i         (head),
    .empty_i        (empty),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_byte_o     (out_byte_o),
    .fragment_end_o (fragment_end_o),
    .run_last_o     (run_last_o),
    .status_o       (status_o)
  );

endmodule

// ===== dv/datagram_split_fragmenter_checker.sv =====
module datagram_split_fragmenter_checker
  import dsf_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata_i,
  input  logic                    in_valid_i,
  input  logic                    in_ready_i,
  input  logic [7:0]              data_byte_i,
  input  logic                    first_byte_i,
  input  logic [LEN_W-1:0]        payload_length_i,
  input  logic signed [SEQ_W-1:0] payload_seq_i,
  input  logic                    out_valid_i,
  input  logic                    out_ready_i,
  input  logic [7:0]              out_byte_i,
  input  logic                    fragment_end_i,
  input  logic                    run_last_i,
  input  logic [STATUS_W-1:0]     status_i,
  output int unsigned             mismatch_count_o,
  output int unsigned             pending_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_FRAGMENTS = 255;

  typedef struct packed {
    logic [7:0]          out_byte;
    logic                frag_end;
    logic                run_last;
    logic [STATUS_W-1:0] status;
  } frag_beat_t;

  // bytes the fragmenter should emit, oldest first
  frag_beat_t fragment_bytes_q[$];

  // register copies and payload state
  logic [SPLIT_W-1:0] split_q;
  logic [MAGIC_W-1:0] magic_q;
  logic [7:0]         idx_q;
  logic [7:0]         total_q;
  logic [15:0]        done_q;
  logic [LEN_W-1:0]   left_q;
  logic [SEQ_W-1:0]   seq_q;
  logic               drop_q;

  int unsigned errors_n  = 0;
  int unsigned pending_n = 0;

  assign mismatch_count_o = errors_n;
  assign pending_count_o  = pending_n;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ns: %s mismatch, got 0x%0h, want 0x%0h", $time, what, got, want);
    errors_n++;
  endtask

  task automatic push_beat(input logic [7:0] b, input logic fe, input logic last,
                           input logic [STATUS_W-1:0] st);
    fragment_bytes_q.push_back('{out_byte: b, frag_end: fe, run_last: last, status: st});
  endtask

  // one accepted input byte: header bytes when a fragment opens, then the body byte
  task automatic fragment_next_byte(input logic [7:0] d, input logic f,
                                    input logic [LEN_W-1:0] len, input logic [SEQ_W-1:0] seq);
    logic [31:0] eff_len;
    logic [31:0] body;
    logic [31:0] n_frag;
    logic        fe;
    if (f) begin
      eff_len = (len == '0) ? 32'd1 : 32'(len);
      seq_q   = seq;
      left_q  = eff_len[LEN_W-1:0];
      idx_q   = '0;
      total_q = '0;
      done_q  = '0;
      drop_q  = 1'b0;
      if (split_q <= HEADER_BYTES) begin
        drop_q = 1'b1;
        left_q = '0;
        push_beat(8'h00, 1'b0, 1'b1, ST_SMALL);
        return;
      end
      body   = 32'(split_q) - HEADER_BYTES;
      n_frag = (eff_len + body - 32'd1) / body;
      if (n_frag > MAX_FRAGMENTS) begin
        drop_q = 1'b1;
        left_q = '0;
        push_beat(8'h00, 1'b0, 1'b1, ST_TOO_MANY);
        return;
      end
      total_q = n_frag[7:0];
    end
    // dropped payload or no payload open
    if (drop_q || left_q == '0) return;
    // split lowered under the header size mid-payload: one body byte per fragment
    body = (split_q <= HEADER_BYTES) ? 32'd1 : 32'(split_q) - HEADER_BYTES;
    if (done_q == '0) begin
      for (int k = 0; k < 4; k++) push_beat(magic_q[8*k +: 8], 1'b0, 1'b0, ST_OK);
      for (int k = 0; k < 4; k++) push_beat(seq_q[8*k +: 8], 1'b0, 1'b0, ST_OK);
      push_beat(total_q, 1'b0, 1'b0, ST_OK);
      push_beat(idx_q, 1'b0, 1'b0, ST_OK);
    end
    done_q = done_q + 16'd1;
    left_q = left_q - LEN_W'(1);
    fe     = (32'(done_q) >= body) || (left_q == '0);
    push_beat(d, fe, 1'b1, ST_OK);
    if (fe) begin
      done_q = '0;
      idx_q  = idx_q + 8'd1;
    end
  endtask

  // compare one output transaction with the oldest expected byte
  task automatic check_out_beat();
    frag_beat_t want;
    if (fragment_bytes_q.size() == 0) begin
      report_mismatch("unexpected output",
                      32'({out_byte_i, fragment_end_i, run_last_i, status_i}), 32'd0);
      return;
    end
    want = fragment_bytes_q.pop_front();
    if (out_byte_i !== want.out_byte)
      report_mismatch("out_byte", 32'(out_byte_i), 32'(want.out_byte));
    if (fragment_end_i !== want.frag_end)
      report_mismatch("fragment_end", 32'(fragment_end_i), 32'(want.frag_end));
    if (run_last_i !== want.run_last)
      report_mismatch("run_last", 32'(run_last_i), 32'(want.run_last));
    if (status_i !== want.status)
      report_mismatch("status", 32'(status_i), 32'(want.status));
  endtask

  // watch config, input and output transactions
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      split_q = SPLIT_SIZE_RST;
      magic_q = MAGIC_WORD_RST;
      idx_q   = '0;
      total_q = '0;
      done_q  = '0;
      left_q  = '0;
      seq_q   = '0;
      drop_q  = 1'b0;
      fragment_bytes_q.delete();
      pending_n <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_SPLIT_SIZE: split_q = cfg_wdata_i[SPLIT_W-1:0];
          REG_MAGIC_WORD: magic_q = cfg_wdata_i[MAGIC_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i)
        fragment_next_byte(data_byte_i, first_byte_i, payload_length_i, payload_seq_i);
      if (out_valid_i && out_ready_i) check_out_beat();
      pending_n <= fragment_bytes_q.size();
    end
  end

endmodule

// ===== dv/datagram_split_fragmenter_top_test.sv =====
module datagram_split_fragmenter_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import dsf_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned CYCLE_LIMIT   = 600000;
  localparam int unsigned RANDOM_ITEMS  = 100;
  localparam int unsigned MAX_GAP       = 16;

  logic                    clk_i             = 1'b0;
  logic                    rst_ni            = 1'b0;
  logic                    cfg_we_i          = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_idx_i         = REG_SPLIT_SIZE;
  logic [CFG_DATA_W-1:0]   cfg_wdata_i       = '0;
  logic                    in_valid_i        = 1'b0;
  logic                    in_ready_o;
  logic [7:0]              data_byte_i       = '0;
  logic                    first_byte_i      = 1'b0;
  logic [LEN_W-1:0]        payload_length_i  = '0;
  logic signed [SEQ_W-1:0] payload_seq_i     = '0;
  logic                    out_valid_o;
  logic                    out_ready_i       = 1'b0;
  logic [7:0]              out_byte_o;
  logic                    fragment_end_o;
  logic                    run_last_o;
  logic [STATUS_W-1:0]     status_o;

  int unsigned mismatch_n;
  int unsigned pending_n;
  int unsigned cycle_n    = 0;
  int unsigned tx_gap_max = MAX_GAP;
  int unsigned rx_gap_max = MAX_GAP;

  // clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  datagram_split_fragmenter_top dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .data_byte_i       (data_byte_i),
    .first_byte_i      (first_byte_i),
    .payload_length_i  (payload_length_i),
    .payload_seq_i     (payload_seq_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .out_byte_o        (out_byte_o),
    .fragment_end_o    (fragment_end_o),
    .run_last_o        (run_last_o),
    .status_o          (status_o)
  );

  datagram_split_fragmenter_checker u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_ready_i        (in_ready_o),
    .data_byte_i       (data_byte_i),
    .first_byte_i      (first_byte_i),
    .payload_length_i  (payload_length_i),
    .payload_seq_i     (payload_seq_i),
    .out_valid_i       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .out_byte_i        (out_byte_o),
    .fragment_end_i    (fragment_end_o),
    .run_last_i        (run_last_o),
    .status_i          (status_o),
    .mismatch_count_o  (mismatch_n),
    .pending_count_o   (pending_n)
  );

  // watchdog
  always @(posedge clk_i) begin
    cycle_n <= cycle_n + 1;
    if (cycle_n == CYCLE_LIMIT) begin
      $display("datagram_split_fragmenter_top verification failed");
      $finish;
    end
  end

  function automatic int unsigned draw_wait(input int unsigned cap);
    if (cap == 0 || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, cap);
  endfunction

  // output side: random stall before each transaction
  initial begin
    int unsigned stall;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      stall = draw_wait(rx_gap_max);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // one input transaction; called and returns at a rising edge
  task automatic push_byte(input logic [7:0] d, input logic f, input logic [LEN_W-1:0] len,
                           input logic [SEQ_W-1:0] seq);
    int unsigned gap;
    gap = draw_wait(tx_gap_max);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    data_byte_i       <= d;
    first_byte_i      <= f;
    payload_length_i  <= len;
    payload_seq_i     <= seq;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // first byte with the given length, then continuation bytes with junk side fields
  task automatic send_payload(input logic [LEN_W-1:0] len, input int unsigned n_bytes);
    push_byte(8'($urandom), 1'b1, len, $urandom);
    for (int unsigned k = 1; k < n_bytes; k++)
      push_byte(8'($urandom), 1'b0, LEN_W'($urandom), $urandom);
  endtask

  // wait until every expected byte is out and the block has gone quiet
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_n != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // stimulus and verdict
  initial begin
    int unsigned sent_n;
    int unsigned kind;
    int unsigned len;
    int unsigned n_bytes;
    logic [SPLIT_W-1:0] split;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset values of the registers
    push_byte(8'hFF, 1'b0, 24'hFF_FFFF, 32'hFFFF_FFFF);      // no payload open yet
    push_byte(8'h00, 1'b1, 24'd0, 32'h8000_0000);            // zero length acts as one
    push_byte(8'hAA, 1'b0, 24'd5, 32'd1);                    // after the payload ended
    push_byte(8'hFF, 1'b1, 24'd3, 32'h7FFF_FFFF);
    push_byte(8'h00, 1'b0, 24'd0, 32'd0);
    push_byte(8'h5A, 1'b0, 24'd0, 32'd0);
    push_byte(8'h01, 1'b1, 24'd5, 32'hFFFF_FFFF);
    push_byte(8'h80, 1'b0, 24'd0, 32'd0);
    push_byte(8'h7E, 1'b1, 24'd1, 32'd0);                    // abandons the open payload
    drain_results();

    // smallest usable split: one body byte per fragment
    cfg_write(REG_SPLIT_SIZE, 32'd11);
    cfg_write(REG_MAGIC_WORD, 32'd0);
    push_byte(8'hC3, 1'b1, 24'd2, 32'h1234_5678);
    push_byte(8'h3C, 1'b0, 24'd0, 32'd0);
    push_byte(8'h11, 1'b1, 24'd256, 32'd7);                  // one fragment too many
    push_byte(8'h22, 1'b0, 24'd0, 32'd0);                    // dropped
    push_byte(8'h33, 1'b1, 24'd255, 32'hA5A5_5A5A);          // exactly the fragment limit
    push_byte(8'h44, 1'b0, 24'd0, 32'd0);
    drain_results();

    // split leaves no body
    cfg_write(REG_SPLIT_SIZE, 32'd10);
    push_byte(8'h55, 1'b1, 24'd1, 32'd9);
    push_byte(8'h66, 1'b0, 24'd0, 32'd0);
    drain_results();
    cfg_write(REG_SPLIT_SIZE, 32'd0);
    push_byte(8'h77, 1'b1, 24'd7, 32'd3);
    drain_results();

    // largest split, longest payloads
    cfg_write(REG_SPLIT_SIZE, 32'd65535);
    cfg_write(REG_MAGIC_WORD, 32'hFFFF_FFFF);
    push_byte(8'h88, 1'b1, 24'hFF_FFFF, 32'd1);
    push_byte(8'h99, 1'b1, 24'd16708875, 32'hDEAD_BEEF);
    push_byte(8'hE7, 1'b0, 24'd0, 32'd0);
    push_byte(8'h0F, 1'b1, 24'd16708876, 32'd2);

    // random phases, each with its own split and idling, and sometimes a new magic
    sent_n = 0;
    while (sent_n < RANDOM_ITEMS) begin
      drain_results();
      case ($urandom_range(0, 9))
        0: split = 16'd11;
        1: split = SPLIT_W'($urandom_range(12, 20));
        2: split = SPLIT_W'($urandom_range(21, 60));
        3: split = 16'd1400;
        4: split = 16'd65535;
        5: split = SPLIT_W'($urandom_range(0, 10));
        6: split = SPLIT_W'($urandom);
        default: split = SPLIT_W'($urandom_range(11, 30));
      endcase
      cfg_write(REG_SPLIT_SIZE, 32'(split));
      if ($urandom_range(0, 1) == 0) cfg_write(REG_MAGIC_WORD, $urandom);
      tx_gap_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, MAX_GAP);
      rx_gap_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, MAX_GAP);
      repeat ($urandom_range(1, 4)) begin
        kind = $urandom_range(0, 9);
        len  = $urandom_range(1, 40);
        case (kind)
          0: begin
            // arbitrary length, mostly over the fragment limit
            send_payload(LEN_W'($urandom), 3);
            sent_n += 3;
          end
          1: begin
            push_byte(8'($urandom), 1'b0, LEN_W'($urandom), $urandom);
            sent_n += 1;
          end
          2: begin
            // possibly cut short by the next payload
            n_bytes = $urandom_range(1, len);
            send_payload(LEN_W'(len), n_bytes);
            sent_n += n_bytes;
          end
          3: begin
            // trailing bytes past the end are ignored
            send_payload(LEN_W'(len), len + 2);
            sent_n += len + 2;
          end
          default: begin
            send_payload(LEN_W'(len), len);
            sent_n += len;
          end
        endcase
        if ($urandom_range(0, 5) == 0) drain_results();
      end
    end

    // split lowered mid-payload: after that every byte closes a fragment
    drain_results();
    tx_gap_max = MAX_GAP;
    rx_gap_max = MAX_GAP;
    cfg_write(REG_SPLIT_SIZE, 32'd12);
    send_payload(24'd300, 3);
    drain_results();
    cfg_write(REG_SPLIT_SIZE, $urandom_range(0, 10));
    repeat (12) push_byte(8'($urandom), 1'b0, LEN_W'($urandom), $urandom);

    drain_results();
    if (mismatch_n == 0 && pending_n == 0) begin
      $display("datagram_split_fragmenter_top verification clean");
    end else begin
      $display("datagram_split_fragmenter_top verification failed");
    end
    $finish;
  end

endmodule
